### rtl/core/rdc_pkg.sv
// Shared types and constants of the radix digit calculator.
package rdc_pkg;

  localparam logic [1:0] CMD_DIGIT_A = 2'd0;
  localparam logic [1:0] CMD_DIGIT_B = 2'd1;
  localparam logic [1:0] CMD_EXECUTE = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_DIV_ZERO = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_NEGATIVE = 3'd4;

  localparam logic [1:0] REG_BASE_A   = 2'd0;
  localparam logic [1:0] REG_BASE_B   = 2'd1;
  localparam logic [1:0] REG_RES_BASE = 2'd2;
  localparam logic [1:0] REG_OPER     = 2'd3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_LC_A = 8'h61;

  // Clamps a base register value to the range 2..16.
  function automatic logic [4:0] clamp_base(input logic [4:0] b);
    logic [4:0] r;
    r = b;
    if (b < 5'd2) r = 5'd2;
    if (b > 5'd16) r = 5'd16;
    return r;
  endfunction

  // Returns {valid, value} for an ASCII character in base b.
  function automatic logic [4:0] digit_value(input logic [7:0] c, input logic [4:0] b);
    logic [3:0] v;
    logic       ok;
    v  = 4'd0;
    ok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - CHAR_ZERO);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - CHAR_UC_A + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - CHAR_LC_A + 8'd10);
    else ok = 1'b0;
    if ({1'b0, v} >= b) ok = 1'b0;
    return {ok, v};
  endfunction

  // Executed job handed from the front to the back.
  typedef struct packed {
    logic [1:0]  oper;
    logic [2:0]  err;
    logic [4:0]  rbase;
    logic [31:0] a;
    logic [31:0] b;
  } job_t;

endpackage

### rtl/core/rdc_front.sv
// Front end: accumulates operands from digit items and issues execute jobs.
module rdc_front #(
  parameter int OperandWidth = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_char,
  input  logic [4:0]        base_a,
  input  logic [4:0]        base_b,
  input  logic [4:0]        res_base,
  input  logic [1:0]        oper,
  input  logic              job_full,
  output logic              in_full,
  output logic              job_push,
  output rdc_pkg::job_t     job
);
  import rdc_pkg::*;

  logic [OperandWidth-1:0] acc_a_r, acc_b_r, acc_sel, acc_new;
  logic [2:0]  err_r, err_nxt;
  logic [4:0]  base_sel, dv;
  logic [OperandWidth+4:0] prod;
  logic        is_digit;

  assign is_digit = (in_command == CMD_DIGIT_A) || (in_command == CMD_DIGIT_B);
  assign acc_sel  = (in_command == CMD_DIGIT_A) ? acc_a_r : acc_b_r;
  assign base_sel = clamp_base((in_command == CMD_DIGIT_A) ? base_a : base_b);
  assign dv       = digit_value(in_char, base_sel);
  assign prod     = ({5'd0, acc_sel} * {{OperandWidth{1'b0}}, base_sel})
                    + {{(OperandWidth+1){1'b0}}, dv[3:0]};
  assign acc_new  = prod[OperandWidth-1:0];

  assign in_full  = job_full;
  assign job_push = in_valid && (in_command == CMD_EXECUTE);

  always_comb begin
    job.oper  = oper;
    job.err   = err_r;
    job.rbase = clamp_base(res_base);
    job.a     = 32'(acc_a_r);
    job.b     = 32'(acc_b_r);
    err_nxt   = err_r;
    if (in_valid && is_digit && err_r == ST_OK) begin
      if (!dv[4]) err_nxt = ST_INVALID;
      else if (prod[OperandWidth+4:OperandWidth] != '0) err_nxt = ST_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r <= '0;
      acc_b_r <= '0;
      err_r   <= ST_OK;
    end else if (in_valid) begin
      if (in_command == CMD_EXECUTE) begin
        acc_a_r <= '0;
        acc_b_r <= '0;
        err_r   <= ST_OK;
      end else begin
        err_r <= err_nxt;
        if (is_digit && dv[4]) begin
          if (in_command == CMD_DIGIT_A) acc_a_r <= acc_new;
          else acc_b_r <= acc_new;
        end
      end
    end
  end
endmodule

### rtl/core/rdc_queue.sv
// Two-entry job queue between the front and the back end.
module rdc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rdc_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rdc_pkg::job_t rdata
);
  import rdc_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> full) else $error("queue lost its full state");
endmodule

### rtl/core/rdc_back.sv
// Back end: computes the result iteratively and emits its digits.
module rdc_back #(
  parameter int MaxResultDigits = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_empty,
  input  rdc_pkg::job_t job,
  output logic          job_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [7:0]    out_char,
  output logic [2:0]    out_status,
  output logic          out_last
);
  import rdc_pkg::*;

  localparam int CntW = $clog2(MaxResultDigits + 1);
  localparam int IdxW = $clog2(MaxResultDigits);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_CONV = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]  state_r;
  logic [63:0] r_r;          // value being converted / quotient
  logic [31:0] d_r;          // divisor for a/b
  logic [32:0] rem_r;        // running remainder
  logic [6:0]  bit_r;        // bit counter for iterative units
  logic [4:0]  rb_r;
  logic [CntW-1:0] n_r;
  logic [3:0]  dstore [MaxResultDigits];
  logic [3:0]  rd_r;
  logic        rd_v_r;
  logic [63:0] pp_r;         // multiply partial product accumulator
  logic [31:0] mb_r;
  logic [15:0] mprod;
  logic [32:0] rem_sh;
  logic [5:0]  crem_sh;
  logic [5:0]  crem_r;
  logic [7:0]  char_r;
  logic [2:0]  stat_r;
  logic        last_r, ov_r;

  assign job_pop   = (state_r == S_IDLE) && !job_empty && !ov_r;
  assign out_empty = !ov_r;
  assign out_char  = char_r;
  assign out_status = stat_r;
  assign out_last  = last_r;

  assign mprod   = 16'(r_r[31:0] & {32{1'b0}});
  assign rem_sh  = {rem_r[31:0], r_r[63]};
  assign crem_sh = {crem_r[4:0], r_r[63]};

  // Digit store: written as each conversion ends; read into rd_r one digit at a time during emission.
  always_ff @(posedge clk) begin
    if (state_r == S_CONV && bit_r == 7'd64)
      dstore[n_r[IdxW-1:0]] <= crem_r[3:0];
  end

  always_ff @(posedge clk) begin
    rd_r <= dstore[IdxW'(n_r - CntW'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      if (out_pop && ov_r) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (job_pop) begin
            rb_r   <= job.rbase;
            n_r    <= '0;
            bit_r  <= '0;
            rem_r  <= '0;
            d_r    <= job.b;
            rd_v_r <= 1'b0;
            if (job.err != ST_OK) begin
              char_r <= '0; stat_r <= job.err; last_r <= 1'b1; ov_r <= 1'b1;
            end else begin
              case (job.oper)
                OP_ADD: begin
                  r_r <= 64'(job.a) + 64'(job.b); crem_r <= '0; state_r <= S_CONV;
                end
                OP_SUB: begin
                  if (job.a < job.b) begin
                    char_r <= '0; stat_r <= ST_NEGATIVE; last_r <= 1'b1; ov_r <= 1'b1;
                  end else begin
                    r_r <= 64'(job.a - job.b); crem_r <= '0; state_r <= S_CONV;
                  end
                end
                OP_MUL: begin
                  r_r <= 64'(job.a); mb_r <= job.b; pp_r <= '0; state_r <= S_MUL;
                end
                default: begin
                  if (job.b == '0) begin
                    char_r <= '0; stat_r <= ST_DIV_ZERO; last_r <= 1'b1; ov_r <= 1'b1;
                  end else begin
                    r_r <= {job.a, 32'd0}; state_r <= S_DIV;
                  end
                end
              endcase
            end
          end
        end
        // Shift-and-add multiply, one bit of B per cycle.
        S_MUL: begin
          if (mb_r[0]) pp_r <= pp_r + r_r;
          r_r   <= {r_r[62:0], 1'b0};
          mb_r  <= {1'b0, mb_r[31:1]};
          bit_r <= bit_r + 7'd1;
          if (bit_r == 7'd31) begin
            r_r     <= mb_r[0] ? pp_r + r_r : pp_r;
            bit_r   <= '0;
            crem_r  <= '0;
            state_r <= S_CONV;
          end
        end
        // Restoring division A / B, one quotient bit per cycle.
        S_DIV: begin
          bit_r <= bit_r + 7'd1;
          if (rem_sh >= {1'b0, d_r}) begin
            rem_r <= rem_sh - {1'b0, d_r};
            r_r   <= {r_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            r_r   <= {r_r[62:0], 1'b0};
          end
          if (bit_r == 7'd31) begin
            bit_r   <= '0;
            crem_r  <= '0;
            state_r <= S_CONV;
          end
        end
        // Division by the result base, one bit per cycle; after the last bit the remainder is stored as a digit.
        S_CONV: begin
          if (bit_r == 7'd64) begin
            n_r    <= n_r + CntW'(1);
            bit_r  <= '0;
            crem_r <= '0;
            if (r_r == '0 || n_r + CntW'(1) == CntW'(MaxResultDigits)) state_r <= S_EMIT;
          end else begin
            bit_r <= bit_r + 7'd1;
            if (crem_sh >= {1'b0, rb_r}) begin
              crem_r <= crem_sh - {1'b0, rb_r};
              r_r    <= {r_r[62:0], 1'b1};
            end else begin
              crem_r <= crem_sh;
              r_r    <= {r_r[62:0], 1'b0};
            end
          end
        end
        // Read the store most significant first; rd_v_r waits for the registered read in rd_r.
        S_EMIT: begin
          if (!rd_v_r) begin
            rd_v_r <= 1'b1;
          end else if (!ov_r || out_pop) begin
            char_r <= (rd_r < 4'd10) ? CHAR_ZERO + 8'(rd_r) : CHAR_UC_A + 8'(rd_r - 4'd10);
            stat_r <= ST_OK;
            last_r <= (n_r == CntW'(1));
            ov_r   <= 1'b1;
            n_r    <= n_r - CntW'(1);
            rd_v_r <= 1'b0;
            if (n_r == CntW'(1)) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic unused_ok;
  assign unused_ok = ^{mprod, rem_r[32]};

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && stat_r != ST_OK |-> last_r) else $error("error item without last");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> n_r != '0) else $error("emitting with no digits");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_pop |=> ov_r && $stable(char_r)) else $error("result dropped");
endmodule

### rtl/core/radix_digit_calculator_top.sv
// Top level of the radix digit calculator.
//
// Input channel: push/full with in_command and in_char. Digit items build
// operand A or B in its configured base; one digit item is taken per cycle
// while full is low. An execute item is queued for the back end, which adds or
// subtracts directly or multiplies or divides one bit per cycle, and then converts
// the result to the result base with a bit-serial divider, up to 64 digits.
// Results leave through empty/pop: each item carries out_char, out_status
// and out_last; an error or negative result is a single item with out_char 0.
// Digits leave most significant first. The front stalls (full high) only
// when two executes are already waiting in the job queue. A stalled receiver
// holds the current result and the back end waits for it.
// Reset (rst_n low, synchronous) clears the operands, the sticky error, the
// queue and any pending output item, and sets the bases to 10 and operation to add.
// Configuration is an APB-style port at byte addresses 0, 4, 8, 12.
module radix_digit_calculator_top #(
  parameter int OPERAND_WIDTH = 32,
  parameter int MAX_RESULT_DIGITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_char,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char,
  output logic [2:0]  out_status,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rdc_pkg::*;

  logic [4:0] cfg_base_a_r, cfg_base_b_r, cfg_res_base_r;
  logic [1:0] cfg_oper_r;
  logic       job_push, q_full, q_empty, q_pop;
  job_t       job_in, job_out;
  logic       wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // Register file: writes land at the access phase; other addresses are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_a_r   <= 5'd10;
      cfg_base_b_r   <= 5'd10;
      cfg_res_base_r <= 5'd10;
      cfg_oper_r     <= OP_ADD;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        REG_BASE_A:   cfg_base_a_r   <= pwdata[4:0];
        REG_BASE_B:   cfg_base_b_r   <= pwdata[4:0];
        REG_RES_BASE: cfg_res_base_r <= pwdata[4:0];
        REG_OPER:     cfg_oper_r     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_BASE_A:   prdata = 32'(cfg_base_a_r);
      REG_BASE_B:   prdata = 32'(cfg_base_b_r);
      REG_RES_BASE: prdata = 32'(cfg_res_base_r);
      default:      prdata = 32'(cfg_oper_r);
    endcase
  end

  rdc_front #(.OperandWidth(OPERAND_WIDTH)) u_front (
    .clk, .rst_n,
    .in_valid(push && !full), .in_command, .in_char,
    .base_a(cfg_base_a_r), .base_b(cfg_base_b_r),
    .res_base(cfg_res_base_r), .oper(cfg_oper_r),
    .job_full(q_full), .in_full(full), .job_push, .job(job_in)
  );

  rdc_queue u_queue (
    .clk, .rst_n, .push(job_push), .wdata(job_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(job_out)
  );

  rdc_back #(.MaxResultDigits(MAX_RESULT_DIGITS)) u_back (
    .clk, .rst_n, .job_empty(q_empty), .job(job_out), .job_pop(q_pop),
    .out_empty(empty), .out_pop(pop), .out_char, .out_status, .out_last
  );
endmodule
